// ----- design/sialu_pkg.sv -----
`default_nettype none
package sialu_pkg;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned ModeWidth = 4;
  localparam int unsigned ErrWidth = 2;
  // one quotient bit per pipeline stage, grouped into pass modules
  localparam int unsigned BitsPerPass = 4;
  localparam int unsigned NumPasses = DataWidth / BitsPerPass;
  localparam int unsigned InWidth = ((ModeWidth + 2 * DataWidth + 7) / 8) * 8;
  localparam int unsigned OutWidth = ((DataWidth + 1 + ErrWidth + 7) / 8) * 8;

  typedef enum logic [ModeWidth-1:0] {
    OP_GT  = 4'd0,
    OP_LT  = 4'd1,
    OP_EQ  = 4'd2,
    OP_NE  = 4'd3,
    OP_GE  = 4'd4,
    OP_LE  = 4'd5,
    OP_ADD = 4'd6,
    OP_SUB = 4'd7,
    OP_MUL = 4'd8,
    OP_DIV = 4'd9,
    OP_REM = 4'd10
  } op_e;

  typedef enum logic [ErrWidth-1:0] {
    ERR_NONE     = 2'd0,
    ERR_DIV_ZERO = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_e;

  // item state travelling with the divider
  typedef struct packed {
    logic                 vld;
    logic                 div_op;    // take the division result
    logic                 rem_op;
    logic                 neg_q;
    logic                 neg_r;
    logic [DataWidth-1:0] fast;      // result of all non-division ops
    logic                 truth;
    logic [ErrWidth-1:0]  err;
    logic [DataWidth-1:0] divisor;   // magnitude
    logic [DataWidth-1:0] quo;       // dividend shifting out, quotient shifting in
    logic [DataWidth-1:0] rem;
  } div_slot_t;
endpackage
`default_nettype wire

// ----- design/sialu_front.sv -----
`default_nettype none
// Decode, compare, add/sub, multiply and division setup in one stage.
module sialu_front import sialu_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  vld_i,
  input  wire logic [ModeWidth-1:0]  mode_i,
  input  wire logic [DataWidth-1:0]  a_i,
  input  wire logic [DataWidth-1:0]  b_i,
  output div_slot_t                  slot_o
);
  div_slot_t slot_d, slot_q;
  logic lt_ab, lt_ba, eq_ab, r;
  logic [DataWidth-1:0] prod;

  assign lt_ab = $signed(a_i) < $signed(b_i);
  assign lt_ba = $signed(b_i) < $signed(a_i);
  assign eq_ab = a_i == b_i;
  assign prod = a_i * b_i;

  always_comb begin
    slot_d = '0;
    r = 1'b0;
    slot_d.vld = vld_i;
    slot_d.divisor = b_i[DataWidth-1] ? DataWidth'(-b_i) : b_i;
    slot_d.quo = a_i[DataWidth-1] ? DataWidth'(-a_i) : a_i;
    slot_d.neg_q = a_i[DataWidth-1] ^ b_i[DataWidth-1];
    slot_d.neg_r = a_i[DataWidth-1];
    case (mode_i)
      OP_GT: r = lt_ba;
      OP_LT: r = lt_ab;
      OP_EQ: r = eq_ab;
      OP_NE: r = !eq_ab;
      OP_GE: r = !lt_ab;
      OP_LE: r = !lt_ba;
      default: r = 1'b0;
    endcase
    case (mode_i)
      OP_GT, OP_LT, OP_EQ, OP_NE, OP_GE, OP_LE: begin
        slot_d.truth = 1'b1;
        slot_d.fast = DataWidth'(r);
      end
      OP_ADD: slot_d.fast = a_i + b_i;
      OP_SUB: slot_d.fast = a_i - b_i;
      OP_MUL: slot_d.fast = prod;
      OP_DIV, OP_REM: begin
        if (b_i == '0) begin
          slot_d.err = ERR_DIV_ZERO;
        end else begin
          slot_d.div_op = (mode_i == OP_DIV);
          slot_d.rem_op = (mode_i == OP_REM);
          if (a_i == {1'b1, {(DataWidth-1){1'b0}}} && b_i == '1) begin
            slot_d.err = ERR_OVERFLOW;
          end
        end
      end
      default: slot_d.fast = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (en_i) begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;
endmodule
`default_nettype wire

// ----- design/sialu_div_pass.sv -----
`default_nettype none
// BitsPerPass restoring division steps, one register stage each.
module sialu_div_pass import sialu_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  div_slot_t slot_i,
  output div_slot_t slot_o
);
  div_slot_t stage_q [BitsPerPass];
  div_slot_t stage_d [BitsPerPass];

  for (genvar s = 0; s < BitsPerPass; s++) begin : g_step
    div_slot_t src;
    logic [DataWidth:0] trial;
    logic [DataWidth-1:0] shifted;
    if (s == 0) begin : g_first
      assign src = slot_i;
    end else begin : g_next
      assign src = stage_q[s-1];
    end
    assign shifted = {src.rem[DataWidth-2:0], src.quo[DataWidth-1]};
    assign trial = {src.rem[DataWidth-1], shifted} - {1'b0, src.divisor};
    always_comb begin
      stage_d[s] = src;
      if (trial[DataWidth]) begin
        stage_d[s].rem = shifted;
        stage_d[s].quo = {src.quo[DataWidth-2:0], 1'b0};
      end else begin
        stage_d[s].rem = trial[DataWidth-1:0];
        stage_d[s].quo = {src.quo[DataWidth-2:0], 1'b1};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stage_q[s] <= '0;
      end else if (en_i) begin
        stage_q[s] <= stage_d[s];
      end
    end
  end

  assign slot_o = stage_q[BitsPerPass-1];
endmodule
`default_nettype wire

// ----- design/signed_integer_alu.sv -----
`default_nettype none
// Signed integer ALU, fully pipelined: one beat accepted per cycle unless
// the output is stalled. Every result passes through one decode stage, one
// stage per quotient bit of the restoring divider and one sign fix-up/output
// stage, whatever the operation. The whole pipeline advances together and
// holds when the output beat is stalled.
module signed_integer_alu import sialu_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  // mode[3:0], operand_a[35:4], operand_b[67:36]
  input  wire logic [InWidth-1:0]  s_axis_tdata,
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // value[31:0], is_truth[32], error_code[34:33]
  output      logic [OutWidth-1:0] m_axis_tdata
);
  logic en;
  div_slot_t chain [NumPasses+1];
  logic [DataWidth-1:0] val_d, val_q;
  logic truth_q;
  logic [ErrWidth-1:0] err_q;
  logic vld_q;

  // advance unless a finished beat is blocked
  assign en = !vld_q || m_axis_tready;
  assign s_axis_tready = en;

  sialu_front u_front (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(s_axis_tvalid),
    .mode_i(s_axis_tdata[ModeWidth-1:0]),
    .a_i(s_axis_tdata[ModeWidth +: DataWidth]),
    .b_i(s_axis_tdata[ModeWidth+DataWidth +: DataWidth]),
    .slot_o(chain[0])
  );

  for (genvar p = 0; p < NumPasses; p++) begin : g_pass
    sialu_div_pass u_pass (
      .clk_i, .rst_ni, .en_i(en), .slot_i(chain[p]), .slot_o(chain[p+1])
    );
  end

  always_comb begin
    div_slot_t f;
    f = chain[NumPasses];
    if (f.div_op) begin
      val_d = f.neg_q ? DataWidth'(-f.quo) : f.quo;
    end else if (f.rem_op) begin
      val_d = f.neg_r ? DataWidth'(-f.rem) : f.rem;
    end else begin
      val_d = f.fast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= chain[NumPasses].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q <= val_d;
      truth_q <= chain[NumPasses].truth;
      err_q <= chain[NumPasses].err;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata = OutWidth'({err_q, truth_q, val_q});

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && truth_q) |-> (val_q[DataWidth-1:1] == '0 && err_q == ERR_NONE))
    else $error("compare result not a single bit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && err_q == ERR_DIV_ZERO) |-> (val_q == '0))
    else $error("divide by zero result not zero");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(chain[NumPasses]))
    else $error("pipeline moved while stalled");
endmodule
`default_nettype wire
